/* rtl/core/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/dae_pkg.sv */
// shared constants, register indexes and saturation helper
// no dependencies
package dae_pkg;

    localparam int CELL_COUNT_DEF = 4096;
    localparam int POLE_MAX_DEF   = 3;
    localparam int BANKS          = 3;
    localparam int FRAC           = 28;
    localparam int PIPE_DEPTH     = 8;

    typedef enum logic [2:0] {
        REG_POLE_COUNT = 3'd0,
        REG_GAIN       = 3'd1,
        REG_DECAY_A    = 3'd2,
        REG_DECAY_B    = 3'd3,
        REG_DECAY_C    = 3'd4,
        REG_DRIVE_A    = 3'd5,
        REG_DRIVE_B    = 3'd6,
        REG_DRIVE_C    = 3'd7
    } reg_index_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* rtl/core/dae_cur_mem.sv */
// pole current memory: one row of pole currents per bank and cell
// synchronous read, zero fill sweep after reset
module dae_cur_mem #(
    parameter int DEPTH = 12288,
    parameter int ROW_W = 96
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ROW_W-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ROW_W-1:0]         wr_data,
    output logic                     busy
);
    localparam int AW = $clog2(DEPTH);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [AW-1:0]    clr_reg;
    logic             busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (clr_reg == AW'(DEPTH - 1))
                busy_reg <= 1'b0;
            else
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

    assign busy = busy_reg;
endmodule

/* rtl/core/debye_ade_field_update.sv */
// Debye medium electric field update. One cell per clock when not stalled by the
// output, a hazard or the zero fill; results leave in input order via stages 1 to 7
// and the output register. Pole currents sit in one memory row per bank and cell,
// read when the item enters and written back from stage 7. An item whose bank and
// cell match one still in flight waits until that write is done. After reset
// the zero fill runs and no item is accepted; register writes are taken at any time.
module debye_ade_field_update
    import dae_pkg::*;
#(
    parameter int CELL_COUNT = CELL_COUNT_DEF,
    parameter int POLE_MAX   = POLE_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode, cell_index, e_present, coef_self, coef_first, first_h_here,
    // first_h_behind, coef_second, second_h_here, second_h_behind, zero pad
    input  logic [271:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // e_updated
    output logic [31:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int DEPTH = BANKS * CELL_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROW_W = POLE_MAX * 32;

    // configuration
    logic [1:0]         pole_count_reg;
    logic signed [31:0] gain_reg;
    logic signed [31:0] decay_reg [3];
    logic signed [31:0] drive_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_count_reg <= 2'd1;
            gain_reg       <= '0;
            decay_reg      <= '{default: '0};
            drive_reg      <= '{default: '0};
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_POLE_COUNT: pole_count_reg <= cfg_data[1:0];
                REG_GAIN:       gain_reg       <= cfg_data;
                REG_DECAY_A:    decay_reg[0]   <= cfg_data;
                REG_DECAY_B:    decay_reg[1]   <= cfg_data;
                REG_DECAY_C:    decay_reg[2]   <= cfg_data;
                REG_DRIVE_A:    drive_reg[0]   <= cfg_data;
                REG_DRIVE_B:    drive_reg[1]   <= cfg_data;
                REG_DRIVE_C:    drive_reg[2]   <= cfg_data;
                default:        ;
            endcase
        end
    end

    logic [1:0]         poles_eff;
    logic [POLE_MAX-1:0] act;
    logic signed [31:0] weight [POLE_MAX];

    always_comb
    begin
        if (pole_count_reg == 2'd0)
            poles_eff = 2'd1;
        else if (32'(pole_count_reg) > POLE_MAX)
            poles_eff = 2'(POLE_MAX);
        else
            poles_eff = pole_count_reg;
        for (int p = 0; p < POLE_MAX; p++)
        begin
            act[p]    = (p < 32'(poles_eff));
            weight[p] = 32'((33'sd268435456 + 33'(decay_reg[p])) >>> 1);
        end
    end

    // input fields
    logic [1:0]         in_mode;
    logic [11:0]        in_cell;
    logic signed [31:0] in_e, in_cs, in_cf, in_h1, in_h1b, in_cc, in_h2, in_h2b;
    logic               in_hb;
    logic [AW-1:0]      in_addr;

    assign in_mode = s_tdata[1:0];
    assign in_cell = s_tdata[13:2];
    assign in_e    = s_tdata[45:14];
    assign in_cs   = s_tdata[77:46];
    assign in_cf   = s_tdata[109:78];
    assign in_h1   = s_tdata[141:110];
    assign in_h1b  = s_tdata[173:142];
    assign in_cc   = s_tdata[205:174];
    assign in_h2   = s_tdata[237:206];
    assign in_h2b  = s_tdata[269:238];
    assign in_hb   = (32'(in_mode) < BANKS) && (32'(in_cell) < CELL_COUNT);
    assign in_addr = AW'(32'(in_mode) * CELL_COUNT + 32'(in_cell));

    // pipeline control
    logic               ovalid_reg;
    logic [31:0]        odata_reg;
    logic [7:1]         v_reg;
    logic               adv, hazard, busy, in_acc;
    logic               h_reg [1:7];
    logic [AW-1:0]      a_reg [1:7];

    assign adv = !ovalid_reg || m_tready;

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 1; k <= 7; k++)
            if (v_reg[k] && h_reg[k] && in_hb && a_reg[k] == in_addr)
                hazard = 1'b1;
    end

    assign s_tready = adv && !busy && !hazard;
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg      <= {v_reg[6:1], in_acc};
            ovalid_reg <= v_reg[7];
        end
    end

    // memory
    logic [ROW_W-1:0]   rd_data, wr_data;
    logic               wr_en;

    dae_cur_mem #(
        .DEPTH (DEPTH),
        .ROW_W (ROW_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (a_reg[7]),
        .wr_data (wr_data),
        .busy    (busy)
    );

    // datapath registers
    logic signed [31:0] eo_reg [1:5];
    logic signed [31:0] cs1_reg, cf1_reg, cc1_reg, d1_1_reg, d2_1_reg;
    logic signed [31:0] j1 [POLE_MAX];
    logic signed [31:0] j_reg [2:7][POLE_MAX];
    logic signed [63:0] ps2_reg, pf2_reg, pc2_reg;
    logic signed [63:0] pw2_reg [POLE_MAX];
    logic signed [37:0] yee_reg [3:4];
    logic signed [31:0] js3_reg;
    logic signed [63:0] gp4_reg;
    logic signed [63:0] dp4_reg [POLE_MAX];
    logic signed [31:0] e_reg [5:7];
    logic signed [35:0] dq_reg [5:7][POLE_MAX];
    logic signed [31:0] de6_reg;
    logic signed [63:0] rp7_reg [POLE_MAX];

    logic signed [37:0] yee_n;
    logic signed [65:0] acc_n;
    logic signed [31:0] jn [POLE_MAX];

    always_comb
    begin
        for (int p = 0; p < POLE_MAX; p++)
            j1[p] = rd_data[p*32 +: 32];
        yee_n = 38'(ps2_reg >>> FRAC) + 38'(pf2_reg >>> FRAC) + 38'(pc2_reg >>> FRAC);
        acc_n = '0;
        for (int p = 0; p < POLE_MAX; p++)
            if (act[p])
                acc_n = acc_n + 66'(pw2_reg[p]);
        for (int p = 0; p < POLE_MAX; p++)
        begin
            jn[p] = sat32(40'(dq_reg[7][p]) + 40'(rp7_reg[p] >>> FRAC));
            wr_data[p*32 +: 32] = act[p] ? jn[p] : j_reg[7][p];
        end
    end

    assign wr_en = adv && v_reg[7] && h_reg[7];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg[1]  <= in_hb;
            a_reg[1]  <= in_addr;
            for (int k = 2; k <= 7; k++)
            begin
                h_reg[k] <= h_reg[k-1];
                a_reg[k] <= a_reg[k-1];
            end
            eo_reg[1] <= in_e;
            for (int k = 2; k <= 5; k++)
                eo_reg[k] <= eo_reg[k-1];
            cs1_reg   <= in_cs;
            cf1_reg   <= in_cf;
            cc1_reg   <= in_cc;
            d1_1_reg  <= sat32(40'(in_h1) - 40'(in_h1b));
            d2_1_reg  <= sat32(40'(in_h2) - 40'(in_h2b));
            j_reg[2]  <= j1;
            for (int k = 3; k <= 7; k++)
                j_reg[k] <= j_reg[k-1];
            // stage 2
            ps2_reg <= cs1_reg * eo_reg[1];
            pf2_reg <= cf1_reg * d1_1_reg;
            pc2_reg <= cc1_reg * d2_1_reg;
            for (int p = 0; p < POLE_MAX; p++)
                pw2_reg[p] <= weight[p] * j1[p];
            // stage 3, no current term without a bank
            yee_reg[3] <= yee_n;
            js3_reg    <= h_reg[2] ? sat32(40'(acc_n >>> FRAC)) : '0;
            // stage 4
            yee_reg[4] <= yee_reg[3];
            gp4_reg    <= gain_reg * js3_reg;
            for (int p = 0; p < POLE_MAX; p++)
                dp4_reg[p] <= decay_reg[p] * j_reg[3][p];
            // stage 5
            e_reg[5] <= sat32(40'(yee_reg[4]) + 40'(gp4_reg >>> FRAC));
            for (int p = 0; p < POLE_MAX; p++)
                dq_reg[5][p] <= 36'(dp4_reg[p] >>> FRAC);
            // stage 6
            e_reg[6]  <= e_reg[5];
            dq_reg[6] <= dq_reg[5];
            de6_reg   <= sat32(40'(e_reg[5]) - 40'(eo_reg[5]));
            // stage 7
            e_reg[7]  <= e_reg[6];
            dq_reg[7] <= dq_reg[6];
            for (int p = 0; p < POLE_MAX; p++)
                rp7_reg[p] <= drive_reg[p] * de6_reg;
            if (v_reg[7])
                odata_reg <= e_reg[7];
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
endmodule

/* rtl/core/dae_checker.sv */
// port-level checker for the field update block, bound to the top level
// depends on dae_pkg and assert_macros.svh
`include "assert_macros.svh"

module dae_checker
    import dae_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    logic [3:0] cnt_reg;
    logic       in_t, out_t;

    assign in_t  = s_tvalid && s_tready;
    assign out_t = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_reg + 4'(in_t) - 4'(out_t);
    end

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPL(a_no_phantom, m_tvalid, cnt_reg != 4'd0)
    `ASSERT_IMPL(a_bounded, 1'b1, 32'(cnt_reg) <= PIPE_DEPTH)
endmodule

bind debye_ade_field_update dae_checker u_dae_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
